[src/qse_pkg.sv]
// Shared types and constants for the quicksort engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package qse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int STACK_DEPTH  = 64;
  localparam int STK_IDX_W    = $clog2(STACK_DEPTH);
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_SE,
    OP_WR_S_B,
    OP_WR_E_A,
    OP_POP_RD,
    OP_POP_LD,
    OP_PIV,
    OP_RD_I_OU,
    OP_WR_OU_A,
    OP_WR_I_B,
    OP_INC_I,
    OP_RD_FIN,
    OP_WR_P_A,
    OP_WR_OUM1_PIV,
    OP_INC_S,
    OP_FIN,
    OP_RD_K,
    OP_OUT_LD
  } qse_op_e;

  typedef struct packed {
    qse_op_e op;
  } qse_cmd_t;

  typedef struct packed {
    logic short_range; // end <= start + 1
    logic e_gt_s;      // end > start
    logic lt_b_a;      // read port B value below read port A value
    logic lt_a_piv;    // read port A value below the pivot
    logic i_gt_e;      // scan index past the end of the range
    logic sp_zero;     // range stack empty
    logic n_ge2;       // batch holds two or more values after this load
    logic k_last;      // emit index points at the last stored value
    logic out_free;    // output register can take a new beat
  } qse_sts_t;

  typedef struct packed {
    logic [STK_IDX_W-1:0] s;
    logic [STK_IDX_W-1:0] e;
  } qse_range_t;

endpackage

[src/qse_dp.sv]
// Datapath of the quicksort engine: element store, range stack, index registers
// and the output register. Depends on qse_pkg; driven by qse_ctrl commands.
`timescale 1ns / 1ps

module qse_dp import qse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  input  logic                     out_stall_i,
  input  qse_cmd_t                 cmd_i,
  output qse_sts_t                 sts_o,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     final_res_o,
  output logic                     dropped_o
);

  logic signed [DATA_W-1:0] store_mem [MAX_ELEMENTS];
  qse_range_t               stack_mem [STACK_DEPTH];

  logic [CNT_W-1:0]         count_q, s_q, e_q, ou_q, i_q, k_q;
  logic [SP_W-1:0]          sp_q;
  logic                     ovf_q;
  logic signed [DATA_W-1:0] piv_q, rd_a_q, rd_b_q;
  qse_range_t               stk_rd_q;
  logic                     out_valid_q, final_q, dropped_q;
  logic signed [DATA_W-1:0] out_value_q;

  logic                     room;
  logic [CNT_W-1:0]         n_next, ou_m1;
  logic                     st_we, rd_en, push;
  logic [IDX_W-1:0]         st_wa, ra_a, ra_b;
  logic signed [DATA_W-1:0] st_wd;

  assign room   = count_q < CNT_W'(MAX_ELEMENTS);
  assign n_next = room ? count_q + CNT_W'(1) : count_q;
  assign ou_m1  = ou_q - CNT_W'(1);
  assign push   = (cmd_i.op == OP_FIN) && (e_q > ou_q) && (sp_q < SP_W'(STACK_DEPTH));

  always_comb begin
    st_we = 1'b0;
    st_wa = '0;
    st_wd = rd_a_q;
    rd_en = 1'b0;
    ra_a  = '0;
    ra_b  = '0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        st_we = room;
        st_wa = count_q[IDX_W-1:0];
        st_wd = value_i;
      end
      OP_RD_SE: begin
        rd_en = 1'b1;
        ra_a  = s_q[IDX_W-1:0];
        ra_b  = e_q[IDX_W-1:0];
      end
      OP_WR_S_B: begin
        st_we = 1'b1;
        st_wa = s_q[IDX_W-1:0];
        st_wd = rd_b_q;
      end
      OP_WR_E_A: begin
        st_we = 1'b1;
        st_wa = e_q[IDX_W-1:0];
      end
      OP_RD_I_OU: begin
        rd_en = 1'b1;
        ra_a  = i_q[IDX_W-1:0];
        ra_b  = ou_q[IDX_W-1:0];
      end
      OP_WR_OU_A: begin
        st_we = 1'b1;
        st_wa = ou_q[IDX_W-1:0];
      end
      OP_WR_I_B: begin
        st_we = 1'b1;
        st_wa = i_q[IDX_W-1:0];
        st_wd = rd_b_q;
      end
      OP_RD_FIN: begin
        rd_en = 1'b1;
        ra_a  = ou_m1[IDX_W-1:0];
      end
      OP_WR_P_A: begin
        // The pivot sits at the start of the range during the whole pass.
        st_we = 1'b1;
        st_wa = s_q[IDX_W-1:0];
      end
      OP_WR_OUM1_PIV: begin
        st_we = 1'b1;
        st_wa = ou_m1[IDX_W-1:0];
        st_wd = piv_q;
      end
      OP_RD_K: begin
        rd_en = 1'b1;
        ra_a  = k_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (rd_en) begin
      rd_a_q <= store_mem[ra_a];
      rd_b_q <= store_mem[ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[STK_IDX_W-1:0]] <= '{s: ou_q[STK_IDX_W-1:0], e: e_q[STK_IDX_W-1:0]};
    end
    if (cmd_i.op == OP_POP_RD) begin
      stk_rd_q <= stack_mem[sp_q[STK_IDX_W-1:0] - STK_IDX_W'(1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      s_q         <= '0;
      e_q         <= '0;
      ou_q        <= '0;
      i_q         <= '0;
      k_q         <= '0;
      sp_q        <= '0;
      piv_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      final_q     <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT_LD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          count_q <= n_next;
          if (!room) begin
            ovf_q <= 1'b1;
          end
          if (last_i) begin
            s_q  <= '0;
            e_q  <= n_next - CNT_W'(1);
            sp_q <= '0;
            k_q  <= '0;
          end
        end
        OP_POP_RD: sp_q <= sp_q - SP_W'(1);
        OP_POP_LD: begin
          s_q <= CNT_W'(stk_rd_q.s);
          e_q <= CNT_W'(stk_rd_q.e);
        end
        OP_PIV: begin
          piv_q <= rd_a_q;
          ou_q  <= s_q + CNT_W'(1);
          i_q   <= s_q + CNT_W'(1);
        end
        OP_WR_I_B: begin
          ou_q <= ou_q + CNT_W'(1);
          i_q  <= i_q + CNT_W'(1);
        end
        OP_INC_I: i_q <= i_q + CNT_W'(1);
        OP_INC_S: s_q <= s_q + CNT_W'(1);
        OP_FIN: begin
          if (push) begin
            sp_q <= sp_q + SP_W'(1);
          end
          e_q <= ou_m1;
        end
        OP_OUT_LD: begin
          out_value_q <= rd_a_q;
          final_q     <= sts_o.k_last;
          dropped_q   <= ovf_q;
          k_q         <= k_q + CNT_W'(1);
          if (sts_o.k_last) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.short_range = e_q <= s_q + CNT_W'(1);
    sts_o.e_gt_s      = e_q > s_q;
    sts_o.lt_b_a      = rd_b_q < rd_a_q;
    sts_o.lt_a_piv    = rd_a_q < piv_q;
    sts_o.i_gt_e      = i_q > e_q;
    sts_o.sp_zero     = sp_q == '0;
    sts_o.n_ge2       = n_next >= CNT_W'(2);
    sts_o.k_last      = (k_q + CNT_W'(1)) == count_q;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_res_o    = final_q;
  assign dropped_o      = dropped_q;

endmodule

[src/qse_ctrl.sv]
// Controller of the quicksort engine: a state machine that sequences loading,
// partitioning, range stack pops and emission. Depends on qse_pkg.
`timescale 1ns / 1ps

module qse_ctrl import qse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_i,
  input  qse_sts_t sts_i,
  output qse_cmd_t cmd_o,
  output logic     in_stall_o
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RANGE     = 5'd1;
  localparam logic [4:0] S_SMALL_CMP = 5'd2;
  localparam logic [4:0] S_SMALL_W1  = 5'd3;
  localparam logic [4:0] S_SMALL_W2  = 5'd4;
  localparam logic [4:0] S_POP       = 5'd5;
  localparam logic [4:0] S_POP_LD    = 5'd6;
  localparam logic [4:0] S_PART_INIT = 5'd7;
  localparam logic [4:0] S_PART_RD   = 5'd8;
  localparam logic [4:0] S_PART_CMP  = 5'd9;
  localparam logic [4:0] S_PART_W1   = 5'd10;
  localparam logic [4:0] S_PART_W2   = 5'd11;
  localparam logic [4:0] S_FIN_CMP   = 5'd12;
  localparam logic [4:0] S_FIN_W1    = 5'd13;
  localparam logic [4:0] S_FIN_W2    = 5'd14;
  localparam logic [4:0] S_FIN_END   = 5'd15;
  localparam logic [4:0] S_EMIT_RD   = 5'd16;
  localparam logic [4:0] S_EMIT_LD   = 5'd17;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (last_i) begin
            state_d = sts_i.n_ge2 ? S_RANGE : S_EMIT_RD;
          end
        end
      end
      S_RANGE: begin
        cmd_o.op = OP_RD_SE;
        if (!sts_i.short_range) begin
          state_d = S_PART_INIT;
        end else if (sts_i.e_gt_s) begin
          state_d = S_SMALL_CMP;
        end else begin
          state_d = S_POP;
        end
      end
      S_SMALL_CMP: state_d = sts_i.lt_b_a ? S_SMALL_W1 : S_POP;
      S_SMALL_W1: begin
        cmd_o.op = OP_WR_S_B;
        state_d  = S_SMALL_W2;
      end
      S_SMALL_W2: begin
        cmd_o.op = OP_WR_E_A;
        state_d  = S_POP;
      end
      S_POP: begin
        if (sts_i.sp_zero) begin
          state_d = S_EMIT_RD;
        end else begin
          cmd_o.op = OP_POP_RD;
          state_d  = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd_o.op = OP_POP_LD;
        state_d  = S_RANGE;
      end
      S_PART_INIT: begin
        cmd_o.op = OP_PIV;
        state_d  = S_PART_RD;
      end
      S_PART_RD: begin
        if (sts_i.i_gt_e) begin
          cmd_o.op = OP_RD_FIN;
          state_d  = S_FIN_CMP;
        end else begin
          cmd_o.op = OP_RD_I_OU;
          state_d  = S_PART_CMP;
        end
      end
      S_PART_CMP: begin
        if (sts_i.lt_a_piv) begin
          state_d = S_PART_W1;
        end else begin
          cmd_o.op = OP_INC_I;
          state_d  = S_PART_RD;
        end
      end
      S_PART_W1: begin
        cmd_o.op = OP_WR_OU_A;
        state_d  = S_PART_W2;
      end
      S_PART_W2: begin
        cmd_o.op = OP_WR_I_B;
        state_d  = S_PART_RD;
      end
      S_FIN_CMP: begin
        if (sts_i.lt_a_piv) begin
          state_d = S_FIN_W1;
        end else begin
          cmd_o.op = OP_INC_S;
          state_d  = S_FIN_END;
        end
      end
      S_FIN_W1: begin
        cmd_o.op = OP_WR_P_A;
        state_d  = S_FIN_W2;
      end
      S_FIN_W2: begin
        cmd_o.op = OP_WR_OUM1_PIV;
        state_d  = S_FIN_END;
      end
      S_FIN_END: begin
        cmd_o.op = OP_FIN;
        state_d  = S_RANGE;
      end
      S_EMIT_RD: begin
        cmd_o.op = OP_RD_K;
        state_d  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT_LD;
          state_d  = sts_i.k_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

[src/quicksort_engine_unit.sv]
// Top level of the quicksort engine: joins the controller and the datapath.
// Depends on qse_pkg, qse_ctrl and qse_dp.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_stall_o    value_i, last_i
// output   out        out_valid_o / out_stall_i  sorted_value_o, final_res_o, dropped_o
//
// Loading takes one input beat per cycle while the engine is idle.
// The sort runs in a single-ported-write element store: each scanned element of a
// partition pass is read and compared with the pivot, and written back only when
// it is swapped, each of the two swap writes in its own step.
// Each result then goes out in two steps (store read, output register load), the load waiting while the output stalls.
// Reset clears the counters, the range stack pointer and the output valid; the
// store needs no clearing pass. A stalled output holds its beat, and input beats
// of the next batch are accepted while the final beat of a batch still waits.

module quicksort_engine_unit import qse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     final_res_o,
  output logic                     dropped_o
);

  // The controller only issues one datapath operation per cycle and reads back
  // the comparison and counter flags; all data stays inside the datapath.
  qse_cmd_t cmd;
  qse_sts_t sts;

  qse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath holds the element store, the range stack, the index registers
  // and the output register that decouples the sorter from a stalling consumer.
  qse_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .dropped_o      (dropped_o)
  );

endmodule

[src/qse_checker.sv]
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on qse_pkg and on the ports of quicksort_engine_unit.
`timescale 1ns / 1ps

module qse_checker import qse_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     last_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] sorted_value_o,
  input logic                     final_res_o,
  input logic                     dropped_o
);

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o)
      && $stable(final_res_o) && $stable(dropped_o))
    else $error("output beat changed while stalled");

  // The last beat of a batch ends loading, so input stalls right after it.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after last beat");

  // While loading, only the final beat of the previous batch may still wait.
  a_idle_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> final_res_o)
    else $error("non-final result pending while accepting input");

  // New results appear only while the engine is busy sorting or emitting.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind quicksort_engine_unit qse_checker u_qse_checker (.*);

[dv/quicksort_engine_unit_tb.sv]
// Self-checking testbench for quicksort_engine_unit: batches of signed values go in,
// and every sorted beat that comes out is checked against an in-bench sorter.
// Depends on qse_pkg and the quicksort_engine_unit RTL.
`timescale 1ns / 1ps

module quicksort_engine_unit_tb;
  import qse_pkg::*;

  // Extreme two's-complement values, used by the directed tests and the
  // extreme-value pattern of the random batches.
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Cycles to keep watching the output after the last expected beat.
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_REPORTED  = 10;

  // Content patterns for the random batches. Ascending and descending runs are
  // the worst case for a first-element pivot, so they get their own patterns.
  typedef enum int {
    PAT_RANDOM,
    PAT_DUPS,
    PAT_ASCEND,
    PAT_DESCEND,
    PAT_EXTREME
  } value_pattern_e;

  // One expected output beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     dropped;
  } sorted_beat_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value = '0;
  logic                     last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     dropped;

  // Idle rates in percent, changed between test phases.
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int error_count    = 0;

  // Values of the batch being collected, and whether any of its beats was dropped.
  logic signed [DATA_W-1:0] batch_vals[$];
  logic                     batch_overflow = 1'b0;
  // Sorted beats still owed by the engine, oldest first.
  sorted_beat_t             sorted_beat_q[$];

  quicksort_engine_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_i        (value),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sorted_value_o (sorted_value),
    .final_res_o    (final_res),
    .dropped_o      (dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard limit on the run. The slowest correct run (worst-case pivots on full
  // batches, heavy stalling on both sides) stays far below this.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // Predictor: collects accepted values and, on the beat marked last, sorts
  // them ascending by signed value and queues one expected beat per value.
  // Values that arrive with the store full are discarded, and the batch is
  // flagged as dropped; a last beat that arrives with the store full still
  // starts the sort on what was stored.
  task automatic collect_and_sort(input logic signed [DATA_W-1:0] val, input logic is_last);
    logic signed [DATA_W-1:0] key;
    sorted_beat_t             beat;
    int                       i;
    int                       j;
    int                       n;
    if (batch_vals.size() < MAX_ELEMENTS) begin
      batch_vals = {batch_vals, val};
    end else begin
      batch_overflow = 1'b1;
    end
    if (is_last) begin
      n = batch_vals.size();
      // Plain insertion sort; equal values keep no particular order, which is
      // fine because only the values are visible at the output.
      for (i = 1; i < n; i++) begin
        key = batch_vals[i];
        j = i - 1;
        while (j >= 0 && batch_vals[j] > key) begin
          batch_vals[j+1] = batch_vals[j];
          j--;
        end
        batch_vals[j+1] = key;
      end
      for (i = 0; i < n; i++) begin
        beat.value   = batch_vals[i];
        beat.is_last = (i == n - 1);
        beat.dropped = batch_overflow;
        sorted_beat_q = {sorted_beat_q, beat};
      end
      batch_vals.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // Input side monitor: every accepted beat goes to the predictor. Sampling at
  // the rising edge sees the values from before the edge, since all drivers
  // use nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      collect_and_sort(value, last);
    end
  end

  // Output side: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    sorted_beat_t exp_beat;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (sorted_beat_q.size() == 0) begin
        note_error($sformatf("unexpected beat: value %0d final %b dropped %b",
                             sorted_value, final_res, dropped));
      end else begin
        exp_beat = sorted_beat_q.pop_front();
        if (sorted_value !== exp_beat.value || final_res !== exp_beat.is_last ||
            dropped !== exp_beat.dropped) begin
          note_error($sformatf("expected value %0d final %b dropped %b, got %0d %b %b",
                               exp_beat.value, exp_beat.is_last, exp_beat.dropped,
                               sorted_value, final_res, dropped));
        end
      end
    end
  end

  // Receiver stalls are redrawn every cycle at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sends one beat. Called just after a rising edge, returns just after the edge
  // at which the beat was taken. Valid stays high when the next beat follows at
  // once, so back-to-back beats never see a low pulse.
  task automatic send_beat(input logic signed [DATA_W-1:0] val, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= val;
    last     <= is_last;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Batches of one value: the lone value is both the first and the final beat.
  task automatic test_single_value;
    send_beat(VAL_MIN, 1'b1);
    send_beat(VAL_MAX, 1'b1);
    send_beat('0, 1'b1);
  endtask

  // Two-value batches exercise the compare-and-swap path: swapped, in order, equal.
  task automatic test_pair_swap;
    send_beat(32'sd5, 1'b0);
    send_beat(-32'sd3, 1'b1);
    send_beat(-32'sd3, 1'b0);
    send_beat(32'sd5, 1'b1);
    send_beat(VAL_MAX, 1'b0);
    send_beat(VAL_MAX, 1'b1);
  endtask

  // Extremes of the value range, sign boundaries, alternating bit patterns and
  // duplicates in a single batch.
  task automatic test_extremes;
    send_beat(VAL_MAX, 1'b0);
    send_beat('0, 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(32'shAAAA_AAAA, 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    send_beat('0, 1'b1);
  endtask

  // Fills the store, then sends one more plain beat and a last beat while it
  // is full: both are discarded and every result carries the dropped flag.
  // The single-value batch after it checks that the flag clears again.
  task automatic test_overflow;
    int k;
    for (k = 0; k < MAX_ELEMENTS; k++) begin
      send_beat($urandom, 1'b0);
    end
    send_beat($urandom, 1'b0);
    send_beat($urandom, 1'b1);
    send_beat(32'sd42, 1'b1);
  endtask

  // Random batches: mostly small, some medium, a few exactly full and a few
  // that overflow. Content follows one of the patterns per batch.
  task automatic test_random_batches(input int n_items);
    value_pattern_e           pat;
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] val;
    int                       sent;
    int                       size;
    int                       pick;
    int                       k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        size = $urandom_range(8, 1);
      end else if (pick < 92) begin
        size = $urandom_range(24, 9);
      end else if (pick < 97) begin
        size = MAX_ELEMENTS;
      end else begin
        size = $urandom_range(MAX_ELEMENTS + 4, MAX_ELEMENTS + 1);
      end
      pat  = value_pattern_e'($urandom_range(PAT_EXTREME));
      base = $urandom;
      for (k = 0; k < size; k++) begin
        case (pat)
          PAT_DUPS:    val = $signed($urandom_range(8)) - 4;
          PAT_ASCEND:  val = base + k;
          PAT_DESCEND: val = base - k;
          PAT_EXTREME: begin
            case ($urandom_range(4))
              0:       val = VAL_MIN;
              1:       val = VAL_MAX;
              2:       val = -32'sd1;
              3:       val = 32'sd1;
              default: val = '0;
            endcase
          end
          default:     val = $urandom;
        endcase
        send_beat(val, k == size - 1);
      end
      sent += size;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs with both sides at full rate.
    set_idling(0, 0);
    test_single_value;
    test_pair_swap;
    test_extremes;
    test_overflow;

    // Random part, one phase per idling mix.
    set_idling(0, 0);
    test_random_batches(80);
    set_idling(48, 0);
    test_random_batches(80);
    set_idling(0, 48);
    test_random_batches(80);
    set_idling(13, 13);
    test_random_batches(80);
    in_valid <= 1'b0;

    // Drain: the global time limit catches an engine that never finishes.
    while (sorted_beat_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sorted_beat_q.size() != 0) begin
      note_error($sformatf("%0d expected beats never arrived", sorted_beat_q.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/qse_pkg.sv
src/qse_dp.sv
src/qse_ctrl.sv
src/quicksort_engine_unit.sv
src/qse_checker.sv
dv/quicksort_engine_unit_tb.sv
